// File: rtl/tqd_pkg.sv
// Package of the timed task dispatcher: opcodes, status codes and item types.
// No dependencies.
package tqd_pkg;
    localparam logic [1:0] OP_PUSH_MICRO = 2'd0;
    localparam logic [1:0] OP_PUSH_MACRO = 2'd1;
    localparam logic [1:0] OP_PUSH_EVENT = 2'd2;
    localparam logic [1:0] OP_RUN = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    localparam logic [1:0] DK_NONE = 2'd0;
    localparam logic [1:0] DK_TASK = 2'd1;
    localparam logic [1:0] DK_EVENT = 2'd2;

    localparam logic [1:0] TS_ACTIVE = 2'd0;
    localparam logic [1:0] TS_CLEARED = 2'd1;

    localparam logic [1:0] PH_MICRO = 2'd0;
    localparam logic [1:0] PH_EVENT = 2'd1;
    localparam logic [1:0] PH_MACRO = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now;
        logic [15:0] task_handle;
        logic [1:0]  task_state;
        logic [31:0] task_due;
        logic [31:0] task_period;
        logic [7:0]  event_kind;
        logic [15:0] event_param;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  dispatch_kind;
        logic [15:0] out_handle;
        logic [7:0]  out_event_kind;
        logic [15:0] out_event_param;
        logic        requeued;
        logic        micro_room;
        logic        macro_room;
        logic        event_room;
    } t_out_item;

    // Task record as held in a task queue memory.
    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] handle;
        logic [31:0] due;
        logic [31:0] period;
    } t_task;
endpackage

// File: rtl/tqd_if.sv
// Valid/ready channel interfaces, each carrying one dispatcher item.
// Depends on tqd_pkg through the payload types.
interface tqd_in_if;
    logic              valid;
    logic              ready;
    tqd_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tqd_out_if;
    logic               valid;
    logic               ready;
    tqd_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tqd_task_mem.sv
// Task ring storage: one write port, one registered read port.
// Depends on tqd_pkg.
module tqd_task_mem #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  tqd_pkg::t_task           i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output tqd_pkg::t_task           o_rdata
);
    tqd_pkg::t_task r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/three_queue_timed_task_dispatcher.sv
// Top level of the three-queue timed task dispatcher.
// Depends on tqd_pkg, tqd_if and tqd_task_mem.
//
// Usage: one input channel (i_cmd) takes items with an opcode: push a micro
// task, push a macro task, push an event, or run one step. Every item
// yields exactly one result item on o_rsp with a status, the dispatched task
// or event, a requeue flag and the room flag of each queue.
// A push is done in the read state. A run step issues the read of the head
// slot, waits for the registered memory read, then forms the result and any
// write-back to the macro queue; on an empty phase it ends with status empty.
// One item is in work at a time.
// The next item can be accepted in the cycle after the result is taken.
// The result sits in an output register; while the receiver stalls, the
// result holds and no new item is accepted until it is taken.
// Reset (synchronous, active low) empties all queues and returns to the
// micro phase; queue memory contents are not cleared.
module three_queue_timed_task_dispatcher #(
    parameter int TASK_DEPTH = 16,
    parameter int EVENT_DEPTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    tqd_in_if.sink i_cmd,
    tqd_out_if.source o_rsp
);
    localparam int TW = $clog2(TASK_DEPTH);
    localparam int EW = $clog2(EVENT_DEPTH);
    localparam int TCW = $clog2(TASK_DEPTH + 1);
    localparam int ECW = $clog2(EVENT_DEPTH + 1);
    localparam int CW = (TCW > ECW) ? TCW : ECW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    tqd_pkg::t_in_item r_in;
    tqd_pkg::t_out_item r_out, n_out;
    logic [TW-1:0] r_mi_rd, r_mi_wr, r_ma_rd, r_ma_wr, n_mi_rd, n_mi_wr, n_ma_rd, n_ma_wr;
    logic [EW-1:0] r_ev_rd, r_ev_wr, n_ev_rd, n_ev_wr;
    logic [TCW-1:0] r_mi_cnt, r_ma_cnt, n_mi_cnt, n_ma_cnt;
    logic [ECW-1:0] r_ev_cnt, n_ev_cnt;
    logic [1:0] r_phase, n_phase;
    logic [CW-1:0] r_left, n_left;

    // Memory ports.
    logic mi_we, ma_we, ev_we;
    logic [TW-1:0] ma_waddr;
    tqd_pkg::t_task mi_rdata, ma_rdata, ma_wdata, push_task;
    logic [23:0] r_ev_mem [EVENT_DEPTH];
    logic [23:0] r_ev_rdata;

    assign push_task = '{state: r_in.task_state, handle: r_in.task_handle,
                         due: r_in.task_due, period: r_in.task_period};

    tqd_task_mem #(.DEPTH(TASK_DEPTH)) u_micro (
        .i_clk(i_clk), .i_we(mi_we), .i_waddr(r_mi_wr), .i_wdata(push_task),
        .i_raddr(r_mi_rd), .o_rdata(mi_rdata));
    tqd_task_mem #(.DEPTH(TASK_DEPTH)) u_macro (
        .i_clk(i_clk), .i_we(ma_we), .i_waddr(ma_waddr), .i_wdata(ma_wdata),
        .i_raddr(r_ma_rd), .o_rdata(ma_rdata));

    // Event memory with registered read.
    always_ff @(posedge i_clk) begin
        if (ev_we) begin
            r_ev_mem[r_ev_wr] <= {r_in.event_kind, r_in.event_param};
        end
        r_ev_rdata <= r_ev_mem[r_ev_rd];
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data = r_out;

    logic [1:0] cur_q;
    logic [CW-1:0] cur_cnt, left_eff;
    tqd_pkg::t_task head;
    logic ma_room;

    always_comb begin
        cur_q = (r_phase == 2'd3) ? tqd_pkg::PH_MICRO : r_phase;
        unique case (cur_q)
            tqd_pkg::PH_MICRO: cur_cnt = CW'(r_mi_cnt);
            tqd_pkg::PH_EVENT: cur_cnt = CW'(r_ev_cnt);
            default:           cur_cnt = CW'(r_ma_cnt);
        endcase
        left_eff = (r_left == '0) ? cur_cnt : r_left;
        head = (cur_q == tqd_pkg::PH_MICRO) ? mi_rdata : ma_rdata;
    end

    // Next-state and data path.
    always_comb begin
        n_state = r_state;
        n_out = r_out;
        n_mi_rd = r_mi_rd; n_mi_wr = r_mi_wr; n_mi_cnt = r_mi_cnt;
        n_ma_rd = r_ma_rd; n_ma_wr = r_ma_wr; n_ma_cnt = r_ma_cnt;
        n_ev_rd = r_ev_rd; n_ev_wr = r_ev_wr; n_ev_cnt = r_ev_cnt;
        n_phase = r_phase;
        n_left = r_left;
        mi_we = 1'b0; ma_we = 1'b0; ev_we = 1'b0;
        ma_waddr = r_ma_wr;
        ma_wdata = push_task;
        ma_room = (r_ma_cnt != TCW'(TASK_DEPTH));
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_out = '0;
                n_state = S_OUT;
                unique case (r_in.opcode)
                    tqd_pkg::OP_PUSH_MICRO: begin
                        if (r_mi_cnt != TCW'(TASK_DEPTH)) begin
                            mi_we = 1'b1;
                            n_mi_wr = (r_mi_wr == TW'(TASK_DEPTH - 1)) ? '0 : r_mi_wr + 1'b1;
                            n_mi_cnt = r_mi_cnt + 1'b1;
                        end else begin
                            n_out.status = tqd_pkg::ST_FULL;
                        end
                    end
                    tqd_pkg::OP_PUSH_MACRO: begin
                        if (ma_room) begin
                            ma_we = 1'b1;
                            n_ma_wr = (r_ma_wr == TW'(TASK_DEPTH - 1)) ? '0 : r_ma_wr + 1'b1;
                            n_ma_cnt = r_ma_cnt + 1'b1;
                        end else begin
                            n_out.status = tqd_pkg::ST_FULL;
                        end
                    end
                    tqd_pkg::OP_PUSH_EVENT: begin
                        if (r_ev_cnt != ECW'(EVENT_DEPTH)) begin
                            ev_we = 1'b1;
                            n_ev_wr = (r_ev_wr == EW'(EVENT_DEPTH - 1)) ? '0 : r_ev_wr + 1'b1;
                            n_ev_cnt = r_ev_cnt + 1'b1;
                        end else begin
                            n_out.status = tqd_pkg::ST_FULL;
                        end
                    end
                    default: begin
                        // Run step: empty phase ends at once; otherwise wait for read.
                        n_phase = cur_q;
                        if (left_eff == '0 || cur_cnt == '0) begin
                            n_out.status = tqd_pkg::ST_EMPTY;
                            n_left = '0;
                            n_phase = (cur_q == tqd_pkg::PH_MACRO) ? tqd_pkg::PH_MICRO
                                                                   : cur_q + 2'd1;
                        end else begin
                            n_left = left_eff;
                            n_state = S_EXEC;
                        end
                    end
                endcase
            end
            S_EXEC: begin
                // Pop the head; r_phase is already normalized here.
                n_left = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_phase = (r_phase == tqd_pkg::PH_MACRO) ? tqd_pkg::PH_MICRO
                                                             : r_phase + 2'd1;
                end
                n_state = S_OUT;
                if (r_phase == tqd_pkg::PH_EVENT) begin
                    n_ev_rd = (r_ev_rd == EW'(EVENT_DEPTH - 1)) ? '0 : r_ev_rd + 1'b1;
                    n_ev_cnt = r_ev_cnt - 1'b1;
                    n_out.dispatch_kind = tqd_pkg::DK_EVENT;
                    n_out.out_event_kind = r_ev_rdata[23:16];
                    n_out.out_event_param = r_ev_rdata[15:0];
                end else begin
                    if (r_phase == tqd_pkg::PH_MICRO) begin
                        n_mi_rd = (r_mi_rd == TW'(TASK_DEPTH - 1)) ? '0 : r_mi_rd + 1'b1;
                        n_mi_cnt = r_mi_cnt - 1'b1;
                        ma_room = (r_ma_cnt != TCW'(TASK_DEPTH));
                    end else begin
                        n_ma_rd = (r_ma_rd == TW'(TASK_DEPTH - 1)) ? '0 : r_ma_rd + 1'b1;
                        ma_room = 1'b1;
                    end
                    ma_wdata = head;
                    if (head.state[1]) begin
                        n_out.status = tqd_pkg::ST_NULL;
                    end else if (head.state == tqd_pkg::TS_CLEARED) begin
                        n_out.status = tqd_pkg::ST_OK;
                    end else if (r_in.now < head.due) begin
                        if (ma_room) begin
                            ma_we = 1'b1;
                        end else begin
                            n_out.status = tqd_pkg::ST_FULL;
                        end
                    end else begin
                        n_out.dispatch_kind = tqd_pkg::DK_TASK;
                        n_out.out_handle = head.handle;
                        ma_wdata.due = r_in.now + head.period;
                        if (head.period != '0) begin
                            if (ma_room) begin
                                ma_we = 1'b1;
                            end else begin
                                n_out.status = tqd_pkg::ST_FULL;
                            end
                        end
                    end
                    n_out.requeued = ma_we;
                    // Macro count: minus the pop, plus the write-back.
                    n_ma_cnt = r_ma_cnt
                        - TCW'(r_phase == tqd_pkg::PH_MACRO) + TCW'(ma_we);
                    if (ma_we) begin
                        n_ma_wr = (r_ma_wr == TW'(TASK_DEPTH - 1)) ? '0 : r_ma_wr + 1'b1;
                    end
                end
            end
            default: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
        // Room flags follow the queue counts after this item.
        if (r_state == S_READ || r_state == S_EXEC) begin
            n_out.micro_room = (n_mi_cnt != TCW'(TASK_DEPTH));
            n_out.macro_room = (n_ma_cnt != TCW'(TASK_DEPTH));
            n_out.event_room = (n_ev_cnt != ECW'(EVENT_DEPTH));
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mi_rd <= '0; r_mi_wr <= '0; r_mi_cnt <= '0;
            r_ma_rd <= '0; r_ma_wr <= '0; r_ma_cnt <= '0;
            r_ev_rd <= '0; r_ev_wr <= '0; r_ev_cnt <= '0;
            r_phase <= tqd_pkg::PH_MICRO;
            r_left <= '0;
        end else begin
            r_state <= n_state;
            r_mi_rd <= n_mi_rd; r_mi_wr <= n_mi_wr; r_mi_cnt <= n_mi_cnt;
            r_ma_rd <= n_ma_rd; r_ma_wr <= n_ma_wr; r_ma_cnt <= n_ma_cnt;
            r_ev_rd <= n_ev_rd; r_ev_wr <= n_ev_wr; r_ev_cnt <= n_ev_cnt;
            r_phase <= n_phase;
            r_left <= n_left;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid) begin
            r_in <= i_cmd.data;
        end
        r_out <= n_out;
    end
endmodule

// File: rtl/tqd_checker.sv
// Port-level checks of the dispatcher, bound to the top level.
// Depends on tqd_pkg and tqd_if.
module tqd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input tqd_pkg::t_out_item out_data
);
    // No new item is taken while a result is pending.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input accepted during result");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // An accepted item does not give its result early.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");

    // A dispatched event always has status OK and is never requeued.
    a_event_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.dispatch_kind == tqd_pkg::DK_EVENT
        |-> out_data.status == tqd_pkg::ST_OK && !out_data.requeued)
        else $error("event with bad status");
endmodule

bind three_queue_timed_task_dispatcher tqd_checker u_tqd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_cmd.valid), .in_ready(i_cmd.ready),
    .out_valid(o_rsp.valid), .out_ready(o_rsp.ready), .out_data(o_rsp.data));
